/* rtl/sbt_pkg.sv */
// Shared types, codes and helpers of the simplex basis tracker.
`default_nettype none
package sbt_pkg;

  localparam int IDX_W      = 11;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 2;
  localparam int DET_W      = 4;
  localparam int VER_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [IDX_W-1:0] CNT_MAX = 11'd2047;

  localparam logic [MODE_W-1:0] MODE_BEGIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PIVOT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_INCONS  = 2'd2;

  localparam logic [DET_W-1:0] DET_NONE        = 4'd0;
  localparam logic [DET_W-1:0] DET_ROWS_GT     = 4'd1;
  localparam logic [DET_W-1:0] DET_COUNT       = 4'd2;
  localparam logic [DET_W-1:0] DET_VAR_RANGE   = 4'd3;
  localparam logic [DET_W-1:0] DET_DUPLICATE   = 4'd4;
  localparam logic [DET_W-1:0] DET_INVALID     = 4'd5;
  localparam logic [DET_W-1:0] DET_ROW_RANGE   = 4'd6;
  localparam logic [DET_W-1:0] DET_COL_RANGE   = 4'd7;
  localparam logic [DET_W-1:0] DET_ENTER_BASIC = 4'd8;
  localparam logic [DET_W-1:0] DET_LEAVE_MAP   = 4'd9;
  localparam logic [DET_W-1:0] DET_NB_MAP      = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  var_index;
    logic [IDX_W-1:0]  row_index;
    logic              var_bad;
    logic              row_bad;
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } link_t;

  function automatic logic [STAT_W-1:0] status_of(logic [DET_W-1:0] det);
    logic [STAT_W-1:0] s;
    if (det == DET_NONE) begin
      s = ST_OK;
    end else if (det == DET_INVALID || det == DET_LEAVE_MAP || det == DET_NB_MAP) begin
      s = ST_INCONS;
    end else begin
      s = ST_INVALID;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/sbt_if.sv */
// Channel interfaces of the simplex basis tracker: items, results, configuration.
`default_nettype none
interface sbt_in_if;
  import sbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  var_index;
  logic [IDX_W-1:0]  row_index;
  modport source (output valid, mode, var_index, row_index, input ready);
  modport sink   (input valid, mode, var_index, row_index, output ready);
endinterface

interface sbt_out_if;
  import sbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DET_W-1:0]  error_detail;
  logic [VER_W-1:0]  version;
  logic [IDX_W-1:0]  leaving_var;
  modport source (output valid, status, error_detail, version, leaving_var, input ready);
  modport sink   (input valid, status, error_detail, version, leaving_var, output ready);
endinterface

interface sbt_cfg_if;
  import sbt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/simplex_basis_tracker.sv */
// Top level of the simplex basis tracker: configuration registers, front end and core.
// Throughput: one item at a time in the core; a two-entry queue lets the next items in.
// The cost of begin and commit is set by the table sweep, over table entries or columns.
// Reset: synchronous, active low; a clearing pass over all MAX_VARS entries follows, with
//   in_ch.ready low until it ends; configuration writes are taken throughout.
`default_nettype none
module simplex_basis_tracker #(
  parameter int MAX_VARS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sbt_in_if.sink     in_ch,
  sbt_out_if.source  out_ch,
  sbt_cfg_if.sink    cfg_ch
);
  import sbt_pkg::*;

  logic [10:0] row_count_r, column_count_r;
  logic        cfg_wr, cfg_clr;
  cmd_t        head;
  logic        head_valid, pop, init_done;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_clr      = cfg_wr && (cfg_ch.index == CFG_ROW_COUNT ||
                                   cfg_ch.index == CFG_COLUMN_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= '0;
      column_count_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_ch.index == CFG_ROW_COUNT) begin
        row_count_r <= cfg_ch.data;
      end
      if (cfg_ch.index == CFG_COLUMN_COUNT) begin
        column_count_r <= cfg_ch.data;
      end
    end
  end

  sbt_front #(.MAX_VARS(MAX_VARS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .row_count    (row_count_r),
    .column_count (column_count_r),
    .init_done    (init_done),
    .pop          (pop),
    .head         (head),
    .head_valid   (head_valid)
  );

  sbt_core #(.MAX_VARS(MAX_VARS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .row_count    (row_count_r),
    .column_count (column_count_r),
    .cfg_clr      (cfg_clr),
    .cmd          (head),
    .cmd_valid    (head_valid),
    .cmd_pop      (pop),
    .init_done    (init_done),
    .out_ch       (out_ch)
  );

endmodule
`default_nettype wire

/* rtl/sbt_front.sv */
// Front end: accepts items, classifies range errors and queues them for the core.
`default_nettype none
module sbt_front #(
  parameter int MAX_VARS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sbt_in_if.sink                    in_ch,
  input  wire logic [10:0]          row_count,
  input  wire logic [10:0]          column_count,
  input  wire logic                 init_done,
  input  wire logic                 pop,
  output sbt_pkg::cmd_t             head,
  output logic                      head_valid
);
  import sbt_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cls;

  assign in_ch.ready = (cnt_r != 2'd2) && init_done;
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = q_mem[rd_ptr_r];
  assign head_valid  = (cnt_r != 2'd0);

  always_comb begin
    cls.mode      = in_ch.mode;
    cls.var_index = in_ch.var_index;
    cls.row_index = in_ch.row_index;
    cls.var_bad   = (in_ch.var_index >= column_count) ||
                    (32'(in_ch.var_index) >= 32'(MAX_VARS));
    cls.row_bad   = (in_ch.row_index >= row_count) ||
                    (32'(in_ch.row_index) >= 32'(MAX_VARS));
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/sbt_core.sv */
// Back end: basis tables, load/commit/pivot sequencer and result register.
`default_nettype none
module sbt_core #(
  parameter int MAX_VARS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [10:0] row_count,
  input  wire logic [10:0] column_count,
  input  wire logic        cfg_clr,
  input  sbt_pkg::cmd_t    cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_pop,
  output logic             init_done,
  sbt_out_if.source        out_ch
);
  import sbt_pkg::*;

  localparam int AW = $clog2(MAX_VARS);

  typedef enum logic [11:0] {
    S_CLR    = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_ADD_WR = 12'b0000_0000_0100,
    S_CM_RD  = 12'b0000_0000_1000,
    S_CM_WR  = 12'b0000_0001_0000,
    S_PV_RD1 = 12'b0000_0010_0000,
    S_PV_RD2 = 12'b0000_0100_0000,
    S_PV_RD3 = 12'b0000_1000_0000,
    S_PV_WR2 = 12'b0001_0000_0000,
    S_OUT    = 12'b0010_0000_0000
  } state_t;

  function automatic logic [AW-1:0] ix(logic [IDX_W-1:0] x);
    logic [AW+IDX_W-1:0] t;
    t = {{AW{1'b0}}, x};
    return t[AW-1:0];
  endfunction

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  nb_r, nb_nxt;
  logic [IDX_W-1:0]  loaded_r, loaded_nxt;
  logic [DET_W-1:0]  lerr_r, lerr_nxt;
  logic              valid_r, valid_nxt;
  logic [VER_W-1:0]  version_r, version_nxt;
  logic              emit_r, emit_nxt;
  logic              init_r, init_nxt;
  logic [IDX_W-1:0]  l_r, l_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [DET_W-1:0]  det_r, det_nxt;
  logic [IDX_W-1:0]  left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r;
  logic [DET_W-1:0]  out_det_r;
  logic [VER_W-1:0]  out_ver_r;
  logic [IDX_W-1:0]  out_left_r;
  logic              out_load;

  logic [IDX_W-1:0] rbv_mem [MAX_VARS];
  logic [IDX_W-1:0] nbl_mem [MAX_VARS];
  link_t            vrw_mem [MAX_VARS];
  link_t            vsl_mem [MAX_VARS];

  logic             rbv_we, nbl_we, vrw_we, vsl_we;
  logic [AW-1:0]    rbv_wa, nbl_wa, vrw_wa, vsl_wa;
  logic [AW-1:0]    rbv_ra, nbl_ra, vrw_ra, vsl_ra;
  logic [IDX_W-1:0] rbv_wd, nbl_wd, rbv_q, nbl_q;
  link_t            vrw_wd, vsl_wd, vrw_q, vsl_q;

  assign init_done       = init_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_stat_r;
  assign out_ch.error_detail = out_det_r;
  assign out_ch.version      = out_ver_r;
  assign out_ch.leaving_var  = out_left_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    clr_nxt     = clr_r;
    j_nxt       = j_r;
    nb_nxt      = nb_r;
    loaded_nxt  = loaded_r;
    lerr_nxt    = lerr_r;
    valid_nxt   = valid_r;
    version_nxt = version_r;
    emit_nxt    = emit_r;
    init_nxt    = init_r;
    l_nxt       = l_r;
    pos_nxt     = pos_r;
    det_nxt     = det_r;
    left_nxt    = left_r;
    cmd_pop     = 1'b0;
    out_load    = 1'b0;
    rbv_we = 1'b0; rbv_wa = '0; rbv_wd = '0; rbv_ra = ix(cmd.row_index);
    vrw_we = 1'b0; vrw_wa = '0; vrw_wd = '0; vrw_ra = ix(cmd.var_index);
    nbl_we = 1'b0; nbl_wa = '0; nbl_wd = '0; nbl_ra = '0;
    vsl_we = 1'b0; vsl_wa = '0; vsl_wd = '0; vsl_ra = '0;

    case (state_r)
      S_CLR: begin
        vrw_we = 1'b1; vrw_wa = clr_r;
        vsl_we = 1'b1; vsl_wa = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_VARS - 1)) begin
          clr_nxt   = '0;
          init_nxt  = 1'b1;
          state_nxt = emit_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd;
          det_nxt  = DET_NONE;
          left_nxt = '0;
          case (cmd.mode)
            MODE_BEGIN: begin
              valid_nxt  = 1'b0;
              loaded_nxt = '0;
              lerr_nxt   = DET_NONE;
              nb_nxt     = '0;
              emit_nxt   = 1'b1;
              clr_nxt    = '0;
              state_nxt  = S_CLR;
            end
            MODE_ADD: begin
              state_nxt = S_ADD_WR;
            end
            MODE_COMMIT: begin
              valid_nxt = 1'b0;
              state_nxt = S_OUT;
              if (row_count > column_count) begin
                det_nxt = DET_ROWS_GT;
              end else if (loaded_r != row_count ||
                           32'(column_count) > 32'(MAX_VARS)) begin
                det_nxt = DET_COUNT;
              end else if (lerr_r != DET_NONE) begin
                det_nxt = lerr_r;
              end else begin
                nb_nxt = '0;
                j_nxt  = '0;
                if (column_count == '0) begin
                  version_nxt = 32'd1;
                  valid_nxt   = 1'b1;
                end else begin
                  state_nxt = S_CM_RD;
                end
              end
            end
            MODE_PIVOT: begin
              state_nxt = S_OUT;
              if (!valid_r) begin
                det_nxt = DET_INVALID;
              end else if (cmd.row_bad) begin
                det_nxt = DET_ROW_RANGE;
              end else if (cmd.var_bad) begin
                det_nxt = DET_COL_RANGE;
              end else begin
                state_nxt = S_PV_RD1;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_WR: begin
        valid_nxt = 1'b0;
        if (lerr_r == DET_NONE) begin
          if (cmd_r.var_bad) begin
            lerr_nxt = DET_VAR_RANGE;
          end else if (vrw_q.ok) begin
            lerr_nxt = DET_DUPLICATE;
          end else if (loaded_r < row_count && 32'(loaded_r) < 32'(MAX_VARS)) begin
            rbv_we = 1'b1; rbv_wa = ix(loaded_r); rbv_wd = cmd_r.var_index;
            vrw_we = 1'b1; vrw_wa = ix(cmd_r.var_index);
            vrw_wd = '{ok: 1'b1, idx: loaded_r};
          end
        end
        if (loaded_r != CNT_MAX) begin
          loaded_nxt = loaded_r + 11'd1;
        end
        state_nxt = S_OUT;
      end
      S_CM_RD: begin
        vrw_ra    = ix(j_r);
        state_nxt = S_CM_WR;
      end
      S_CM_WR: begin
        vsl_we = 1'b1; vsl_wa = ix(j_r);
        if (!vrw_q.ok) begin
          nbl_we = 1'b1; nbl_wa = ix(nb_r); nbl_wd = j_r;
          vsl_wd = '{ok: 1'b1, idx: nb_r};
          nb_nxt = nb_r + 11'd1;
        end
        if (j_r == column_count - 11'd1) begin
          version_nxt = 32'd1;
          valid_nxt   = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          j_nxt     = j_r + 11'd1;
          state_nxt = S_CM_RD;
        end
      end
      S_PV_RD1: begin
        vrw_ra = ix(rbv_q);
        vsl_ra = ix(cmd_r.var_index);
        l_nxt  = rbv_q;
        if (vrw_q.ok) begin
          det_nxt   = DET_ENTER_BASIC;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PV_RD2;
        end
      end
      S_PV_RD2: begin
        nbl_ra  = ix(vsl_q.idx);
        pos_nxt = vsl_q.idx;
        if (l_r >= column_count || 32'(l_r) >= 32'(MAX_VARS) || !vrw_q.ok ||
            vrw_q.idx != cmd_r.row_index) begin
          det_nxt   = DET_LEAVE_MAP;
          state_nxt = S_OUT;
        end else if (!vsl_q.ok || vsl_q.idx >= nb_r ||
                     32'(vsl_q.idx) >= 32'(MAX_VARS)) begin
          det_nxt   = DET_NB_MAP;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PV_RD3;
        end
      end
      S_PV_RD3: begin
        if (nbl_q != cmd_r.var_index) begin
          det_nxt   = DET_NB_MAP;
          state_nxt = S_OUT;
        end else begin
          rbv_we = 1'b1; rbv_wa = ix(cmd_r.row_index); rbv_wd = cmd_r.var_index;
          vrw_we = 1'b1; vrw_wa = ix(cmd_r.var_index);
          vrw_wd = '{ok: 1'b1, idx: cmd_r.row_index};
          nbl_we = 1'b1; nbl_wa = ix(pos_r); nbl_wd = l_r;
          vsl_we = 1'b1; vsl_wa = ix(l_r);
          vsl_wd = '{ok: 1'b1, idx: pos_r};
          state_nxt = S_PV_WR2;
        end
      end
      S_PV_WR2: begin
        vrw_we = 1'b1; vrw_wa = ix(l_r);
        vsl_we = 1'b1; vsl_wa = ix(cmd_r.var_index);
        version_nxt = version_r + 32'd1;
        left_nxt    = l_r;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          emit_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_clr) begin
      valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rbv_we) begin
      rbv_mem[rbv_wa] <= rbv_wd;
    end
    rbv_q <= rbv_mem[rbv_ra];
  end

  always_ff @(posedge clk) begin
    if (nbl_we) begin
      nbl_mem[nbl_wa] <= nbl_wd;
    end
    nbl_q <= nbl_mem[nbl_ra];
  end

  always_ff @(posedge clk) begin
    if (vrw_we) begin
      vrw_mem[vrw_wa] <= vrw_wd;
    end
    vrw_q <= vrw_mem[vrw_ra];
  end

  always_ff @(posedge clk) begin
    if (vsl_we) begin
      vsl_mem[vsl_wa] <= vsl_wd;
    end
    vsl_q <= vsl_mem[vsl_ra];
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    j_r    <= j_nxt;
    l_r    <= l_nxt;
    pos_r  <= pos_nxt;
    det_r  <= det_nxt;
    left_r <= left_nxt;
    if (out_load) begin
      out_stat_r <= status_of(det_r);
      out_det_r  <= det_r;
      out_ver_r  <= version_r;
      out_left_r <= left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      nb_r        <= '0;
      loaded_r    <= '0;
      lerr_r      <= DET_NONE;
      valid_r     <= 1'b0;
      version_r   <= '0;
      emit_r      <= 1'b0;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nb_r        <= nb_nxt;
      loaded_r    <= loaded_nxt;
      lerr_r      <= lerr_nxt;
      valid_r     <= valid_nxt;
      version_r   <= version_nxt;
      emit_r      <= emit_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_pivot_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PV_WR2 && !cfg_clr) |=> valid_r)
    else $error("basis invalid after completed pivot");

  a_nb_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CM_WR && !vrw_q.ok) |=> (nb_r == $past(nb_r) + 11'd1))
    else $error("nonbasic count did not advance");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

endmodule
`default_nettype wire
